// ===== src/sra_pkg.sv =====
// Shared types and constants of the serial register access responder.
// Holds the channel modes, frame codes, controller states and the command and
// status structs between controller and datapath. Depends on nothing.
`default_nettype none

package sra_pkg;

    // Frame header and response codes.
    localparam logic [7:0] HDR_RD = 8'hAA;
    localparam logic [7:0] HDR_WR = 8'hF0;
    localparam logic [7:0] RSP_RD = 8'h55;
    localparam logic [7:0] RSP_WR = 8'h0F;

    // Modulus of both Fletcher-16 sums.
    localparam logic [8:0] FL_MOD = 9'd255;

    // Reset value of the inter-byte timeout register.
    localparam logic [15:0] TIMEOUT_RST = 16'd1000;

    // What one input item asks for.
    typedef enum logic [1:0] {
        M_BYTE   = 2'd0,
        M_TICK   = 2'd1,
        M_LREAD  = 2'd2,
        M_LWRITE = 2'd3
    } t_mode;

    // Source of an emitted result byte.
    typedef enum logic [2:0] {
        E_HDR,
        E_CNT,
        E_DAT,
        E_S1,
        E_S2,
        E_LOC
    } t_esel;

    // Controller states.
    typedef enum logic [4:0] {
        S_IDLE,
        S_SETTLE,
        S_CHK_RD,
        S_CHK_USE,
        S_DECIDE,
        S_SCAN_RD,
        S_SCAN_USE,
        S_LEN_RD,
        S_LEN_USE,
        S_COPY_RD,
        S_COPY_USE,
        S_EM_HDR,
        S_EM_CNT,
        S_EM_RD,
        S_EM_DAT,
        S_EM_S1,
        S_EM_S2,
        S_LOC_EM
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic  rdy;
        logic  settle_clr;
        logic  chk_start;
        logic  buf_rd;
        logic  chk_use;
        logic  scan_start;
        logic  scan_use;
        logic  len_use;
        logic  copy_start;
        logic  copy_use;
        logic  resp_start;
        logic  st_rd;
        logic  emit;
        t_esel esel;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic  in_valid;
        t_mode in_mode;
        logic  fill_zero;
        logic  hdr_aa;
        logic  hdr_f0;
        logic  fill_ge5;
        logic  flen_ok;
        logic  chk_last;
        logic  chk_ok;
        logic  scan_end;
        logic  scan_hit;
        logic  shift_len;
        logic  in_range;
        logic  copy_done;
        logic  emit_done;
        logic  slot_free;
    } t_stat;

    // One step of a Fletcher sum: (a + p) mod 255 with a below 255.
    function automatic logic [7:0] f_mod_add(input logic [7:0] a, input logic [7:0] p);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, p};
        if (s >= FL_MOD) begin
            s = s - FL_MOD;
        end
        return s[7:0];
    endfunction

endpackage

`default_nettype wire

// ===== src/sra_if.sv =====
// Valid/ready channel interfaces of the serial register access responder.
// One carries input items, the other result items. No dependencies.
`default_nettype none

interface sra_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [7:0] rx_byte;
    logic [5:0] local_addr;
    logic [7:0] local_data;

    modport source (output valid, mode, rx_byte, local_addr, local_data, input ready);
    modport sink   (input valid, mode, rx_byte, local_addr, local_data, output ready);
endinterface

interface sra_out_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, kind, out_byte, last, input ready);
    modport sink   (input valid, kind, out_byte, last, output ready);
endinterface

`default_nettype wire

// ===== src/sra_dp.sv =====
// Datapath of the serial register access responder: register store, frame
// buffer, frame counters, Fletcher sums and the output register.
// Depends on sra_pkg and the channel interfaces in sra_if.sv.
`default_nettype none

module sra_dp #(
    parameter int STORE_SIZE = 32
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cfg_we,
    input  wire logic [15:0]    i_cfg_wdata,
    sra_in_if.sink              i_in,
    sra_out_if.source           o_out,
    input  sra_pkg::t_cmd       i_cmd,
    output sra_pkg::t_stat      o_stat
);
    import sra_pkg::*;

    localparam int CAP = STORE_SIZE + 5;
    localparam int BW  = $clog2(CAP);
    localparam int FW  = $clog2(CAP + 1);
    localparam int SW  = $clog2(STORE_SIZE);

    // Memories and their registered read data.
    logic [7:0]            r_buf [CAP];
    logic [7:0]            r_store [STORE_SIZE];
    logic [STORE_SIZE-1:0] r_vld;
    logic [7:0]            r_bq;
    logic [7:0]            r_sq;
    logic                  r_sqv;

    // Frame and sequencing state.
    logic [BW-1:0] r_head, n_head;
    logic [FW-1:0] r_fill, n_fill;
    logic [8:0]    r_flen, n_flen;
    logic [15:0]   r_idle, n_idle;
    logic [15:0]   r_tmo,  n_tmo;
    logic [7:0]    r_hdr,  n_hdr;
    logic [7:0]    r_addr, n_addr;
    logic [7:0]    r_cnt,  n_cnt;
    logic [7:0]    r_cnte, n_cnte;
    logic [FW-1:0] r_n,    n_n;
    logic [FW-1:0] r_idx,  n_idx;
    logic [7:0]    r_s1,   n_s1;
    logic [7:0]    r_s2,   n_s2;
    logic          r_ok1,  n_ok1;
    logic          r_ok2,  n_ok2;

    // Output register.
    logic       r_ov;
    logic       r_kind;
    logic [7:0] r_byte;
    logic       r_last;

    logic          acc;
    t_mode         mode;
    logic          la_ok;
    logic [SW-1:0] la_idx;
    logic          drop;
    logic [FW-1:0] eff_fill;
    logic          rx_hdr;
    logic [BW-1:0] wr_addr;
    logic [BW-1:0] rd_addr;
    logic [8:0]    faddr;
    logic [8:0]    caddr;
    logic [SW-1:0] st_idx;
    logic [8:0]    flen_m2;
    logic [FW:0]   n_p1;
    logic          hit_f0;
    logic          hit_aa;
    logic [7:0]    ebyte;

    // Physical buffer slot of a frame offset from the head.
    function automatic logic [BW-1:0] f_wrap(input logic [FW:0] s);
        logic [FW:0] t;
        t = (s >= (FW+1)'(CAP)) ? s - (FW+1)'(CAP) : s;
        return t[BW-1:0];
    endfunction

    // Input decode and address generation.
    assign acc      = i_in.valid & i_cmd.rdy;
    assign mode     = t_mode'(i_in.mode);
    assign la_ok    = {1'b0, i_in.local_addr} < 7'(STORE_SIZE);
    assign la_idx   = i_in.local_addr[SW-1:0];
    assign drop     = (r_fill >= FW'(CAP)) || (r_idle > r_tmo);
    assign eff_fill = drop ? '0 : r_fill;
    assign rx_hdr   = (i_in.rx_byte == HDR_RD) || (i_in.rx_byte == HDR_WR);
    assign wr_addr  = (eff_fill == '0) ? '0
                    : f_wrap((FW+1)'(r_head) + (FW+1)'(eff_fill));
    assign rd_addr  = f_wrap((FW+1)'(r_head) + (FW+1)'(r_idx));
    assign faddr    = {1'b0, r_addr} + 9'(r_idx);
    assign caddr    = faddr - 9'd3;
    assign st_idx   = i_cmd.copy_use ? caddr[SW-1:0] : faddr[SW-1:0];
    assign flen_m2  = r_flen - 9'd2;
    assign n_p1     = (FW+1)'(r_n) + (FW+1)'(1);
    assign hit_f0   = r_bq == HDR_WR;
    assign hit_aa   = (r_bq == HDR_RD)
                    && ((FW+1)'(r_idx) + (FW+1)'(5) >= (FW+1)'(r_fill));

    // Byte to emit.
    always_comb begin
        unique case (i_cmd.esel)
            E_HDR:         ebyte = (r_hdr == HDR_RD) ? RSP_RD : RSP_WR;
            E_CNT:         ebyte = r_cnte;
            E_DAT, E_LOC:  ebyte = r_sqv ? r_sq : 8'd0;
            E_S1:          ebyte = r_s1;
            E_S2:          ebyte = r_s2;
            default:       ebyte = 8'd0;
        endcase
    end

    // Status to the controller.
    always_comb begin
        o_stat.in_valid  = i_in.valid;
        o_stat.in_mode   = mode;
        o_stat.fill_zero = r_fill == '0;
        o_stat.hdr_aa    = r_hdr == HDR_RD;
        o_stat.hdr_f0    = r_hdr == HDR_WR;
        o_stat.fill_ge5  = r_fill >= FW'(5);
        o_stat.flen_ok   = (r_fill >= FW'(2)) && (9'(r_fill) >= r_flen);
        o_stat.chk_last  = (FW+1)'(r_idx) == n_p1;
        o_stat.chk_ok    = r_ok1 && r_ok2;
        o_stat.scan_end  = r_idx >= r_fill;
        o_stat.scan_hit  = hit_f0 || hit_aa;
        o_stat.shift_len = hit_f0 && ((r_fill - r_idx) >= FW'(2));
        o_stat.in_range  = ({1'b0, r_addr} + {1'b0, r_cnt}) < 9'(STORE_SIZE);
        o_stat.copy_done = 9'(r_idx) == ({1'b0, r_cnt} + 9'd3);
        o_stat.emit_done = 9'(r_idx) == {1'b0, r_cnte};
        o_stat.slot_free = !r_ov || o_out.ready;
    end

    // Next values of the frame and sequencing state.
    always_comb begin
        n_head = r_head;
        n_fill = r_fill;
        n_flen = r_flen;
        n_idle = r_idle;
        n_tmo  = r_tmo;
        n_hdr  = r_hdr;
        n_addr = r_addr;
        n_cnt  = r_cnt;
        n_cnte = r_cnte;
        n_n    = r_n;
        n_idx  = r_idx;
        n_s1   = r_s1;
        n_s2   = r_s2;
        n_ok1  = r_ok1;
        n_ok2  = r_ok2;

        if (i_cfg_we) begin
            n_tmo = i_cfg_wdata;
        end

        // Accepted item: ticks count, bytes enter the frame buffer.
        if (acc) begin
            unique case (mode)
                M_TICK: begin
                    if (r_idle != 16'hFFFF) begin
                        n_idle = r_idle + 16'd1;
                    end
                end
                M_BYTE: begin
                    n_idle = '0;
                    if (eff_fill == '0) begin
                        if (rx_hdr) begin
                            n_head = '0;
                            n_fill = FW'(1);
                            n_hdr  = i_in.rx_byte;
                        end else begin
                            n_fill = '0;
                        end
                    end else begin
                        n_fill = eff_fill + FW'(1);
                        if (eff_fill == FW'(1) && r_hdr == HDR_WR) begin
                            n_flen = {1'b0, i_in.rx_byte} + 9'd5;
                        end
                    end
                end
                default: ;
            endcase
        end

        if (i_cmd.settle_clr) begin
            n_fill = '0;
        end

        // Frame check: sums over the body, then compare the check pair.
        if (i_cmd.chk_start) begin
            n_idx = '0;
            n_s1  = '0;
            n_s2  = '0;
            n_ok1 = 1'b0;
            n_ok2 = 1'b0;
            n_n   = (r_hdr == HDR_RD) ? FW'(3) : flen_m2[FW-1:0];
        end
        if (i_cmd.chk_use) begin
            if (r_idx < r_n) begin
                n_s1 = f_mod_add(r_s1, r_bq);
                n_s2 = f_mod_add(r_s2, n_s1);
            end
            if (r_idx == FW'(1)) begin
                if (r_hdr == HDR_RD) begin
                    n_addr = r_bq;
                end else begin
                    n_cnt = r_bq;
                end
            end
            if (r_idx == FW'(2)) begin
                if (r_hdr == HDR_RD) begin
                    n_cnt = r_bq;
                end else begin
                    n_addr = r_bq;
                end
            end
            if (r_idx == r_n) begin
                n_ok1 = r_bq == r_s1;
            end
            if ((FW+1)'(r_idx) == n_p1) begin
                n_ok2 = r_bq == r_s2;
            end
            n_idx = r_idx + FW'(1);
        end

        // Rescan for a later header after a failed check.
        if (i_cmd.scan_start) begin
            n_idx = FW'(1);
        end
        if (i_cmd.scan_use) begin
            if (hit_f0 || hit_aa) begin
                n_head = f_wrap((FW+1)'(r_head) + (FW+1)'(r_idx));
                n_fill = r_fill - r_idx;
                n_hdr  = r_bq;
                n_idx  = FW'(1);
            end else begin
                n_idx = r_idx + FW'(1);
            end
        end
        if (i_cmd.len_use) begin
            n_flen = {1'b0, r_bq} + 9'd5;
        end

        // Write frame data copy into the store.
        if (i_cmd.copy_start) begin
            n_idx = FW'(3);
        end
        if (i_cmd.copy_use) begin
            n_idx = r_idx + FW'(1);
        end

        // Response: sums restart over the emitted bytes.
        if (i_cmd.resp_start) begin
            n_idx  = '0;
            n_s1   = '0;
            n_s2   = '0;
            n_cnte = o_stat.in_range ? r_cnt : 8'd0;
        end
        if (i_cmd.emit) begin
            if (i_cmd.esel == E_HDR || i_cmd.esel == E_CNT || i_cmd.esel == E_DAT) begin
                n_s1 = f_mod_add(r_s1, ebyte);
                n_s2 = f_mod_add(r_s2, n_s1);
            end
            if (i_cmd.esel == E_DAT) begin
                n_idx = r_idx + FW'(1);
            end
        end
    end

    // Control registers with reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_fill <= '0;
            r_flen <= '0;
            r_idle <= '0;
            r_tmo  <= TIMEOUT_RST;
            r_hdr  <= '0;
            r_ov   <= 1'b0;
        end else begin
            r_head <= n_head;
            r_fill <= n_fill;
            r_flen <= n_flen;
            r_idle <= n_idle;
            r_tmo  <= n_tmo;
            r_hdr  <= n_hdr;
            if (i_cmd.emit) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Working registers and output payload.
    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
        r_cnt  <= n_cnt;
        r_cnte <= n_cnte;
        r_n    <= n_n;
        r_idx  <= n_idx;
        r_s1   <= n_s1;
        r_s2   <= n_s2;
        r_ok1  <= n_ok1;
        r_ok2  <= n_ok2;
        if (i_cmd.emit) begin
            r_kind <= i_cmd.esel == E_LOC;
            r_byte <= ebyte;
            r_last <= (i_cmd.esel == E_LOC) || (i_cmd.esel == E_S2);
        end
    end

    // Frame buffer memory.
    always_ff @(posedge i_clk) begin
        if (acc && mode == M_BYTE && (eff_fill != '0 || rx_hdr)) begin
            r_buf[wr_addr] <= i_in.rx_byte;
        end
        if (i_cmd.buf_rd) begin
            r_bq <= r_buf[rd_addr];
        end
    end

    // Register store memory.
    always_ff @(posedge i_clk) begin
        if (acc && mode == M_LWRITE && la_ok) begin
            r_store[la_idx] <= i_in.local_data;
        end else if (i_cmd.copy_use) begin
            r_store[st_idx] <= r_bq;
        end
        if (acc && mode == M_LREAD) begin
            r_sq <= r_store[la_idx];
        end else if (i_cmd.st_rd) begin
            r_sq <= r_store[st_idx];
        end
    end

    // Store entries read as zero until written.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_sqv <= 1'b0;
        end else begin
            if (acc && mode == M_LWRITE && la_ok) begin
                r_vld[la_idx] <= 1'b1;
            end else if (i_cmd.copy_use) begin
                r_vld[st_idx] <= 1'b1;
            end
            if (acc && mode == M_LREAD) begin
                r_sqv <= la_ok && r_vld[la_idx];
            end else if (i_cmd.st_rd) begin
                r_sqv <= r_vld[st_idx];
            end
        end
    end

    assign i_in.ready     = i_cmd.rdy;
    assign o_out.valid    = r_ov;
    assign o_out.kind     = r_kind;
    assign o_out.out_byte = r_byte;
    assign o_out.last     = r_last;

endmodule

`default_nettype wire

// ===== src/sra_ctrl.sv =====
// Controller of the serial register access responder: sequences frame check,
// rescan, store copy and response emission through the datapath.
// Depends on sra_pkg.
`default_nettype none

module sra_ctrl (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  sra_pkg::t_stat i_stat,
    output sra_pkg::t_cmd  o_cmd
);
    import sra_pkg::*;

    t_state r_state, n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_stat.in_valid) begin
                    if (i_stat.in_mode == M_BYTE) begin
                        n_state = S_SETTLE;
                    end else if (i_stat.in_mode == M_LREAD) begin
                        n_state = S_LOC_EM;
                    end
                end
            end
            S_SETTLE: begin
                if (!i_stat.fill_zero && i_stat.hdr_aa && i_stat.fill_ge5) begin
                    n_state = S_CHK_RD;
                end else if (!i_stat.fill_zero && i_stat.hdr_f0 && i_stat.flen_ok) begin
                    n_state = S_CHK_RD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_CHK_RD:  n_state = S_CHK_USE;
            S_CHK_USE: n_state = i_stat.chk_last ? S_DECIDE : S_CHK_RD;
            S_DECIDE: begin
                if (!i_stat.chk_ok) begin
                    n_state = S_SCAN_RD;
                end else if (i_stat.hdr_aa || !i_stat.in_range) begin
                    n_state = S_EM_HDR;
                end else begin
                    n_state = S_COPY_RD;
                end
            end
            S_SCAN_RD:  n_state = i_stat.scan_end ? S_IDLE : S_SCAN_USE;
            S_SCAN_USE: begin
                if (!i_stat.scan_hit) begin
                    n_state = S_SCAN_RD;
                end else if (i_stat.shift_len) begin
                    n_state = S_LEN_RD;
                end else begin
                    n_state = S_SETTLE;
                end
            end
            S_LEN_RD:   n_state = S_LEN_USE;
            S_LEN_USE:  n_state = S_SETTLE;
            S_COPY_RD:  n_state = i_stat.copy_done ? S_EM_HDR : S_COPY_USE;
            S_COPY_USE: n_state = S_COPY_RD;
            S_EM_HDR: begin
                if (i_stat.slot_free) begin
                    n_state = S_EM_CNT;
                end
            end
            S_EM_CNT: begin
                if (i_stat.slot_free) begin
                    n_state = i_stat.hdr_aa ? S_EM_RD : S_EM_S1;
                end
            end
            S_EM_RD:  n_state = i_stat.emit_done ? S_EM_S1 : S_EM_DAT;
            S_EM_DAT: begin
                if (i_stat.slot_free) begin
                    n_state = S_EM_RD;
                end
            end
            S_EM_S1: begin
                if (i_stat.slot_free) begin
                    n_state = S_EM_S2;
                end
            end
            S_EM_S2, S_LOC_EM: begin
                if (i_stat.slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Commands for the current state.
    always_comb begin
        o_cmd      = '0;
        o_cmd.esel = E_HDR;
        unique case (r_state)
            S_IDLE: o_cmd.rdy = 1'b1;
            S_SETTLE: begin
                if (!i_stat.fill_zero) begin
                    if (i_stat.hdr_aa) begin
                        o_cmd.chk_start = i_stat.fill_ge5;
                    end else if (i_stat.hdr_f0) begin
                        o_cmd.chk_start = i_stat.flen_ok;
                    end else begin
                        o_cmd.settle_clr = 1'b1;
                    end
                end
            end
            S_CHK_RD, S_LEN_RD: o_cmd.buf_rd = 1'b1;
            S_CHK_USE:          o_cmd.chk_use = 1'b1;
            S_DECIDE: begin
                if (!i_stat.chk_ok) begin
                    o_cmd.scan_start = 1'b1;
                end else if (i_stat.hdr_aa || !i_stat.in_range) begin
                    o_cmd.resp_start = 1'b1;
                end else begin
                    o_cmd.copy_start = 1'b1;
                end
            end
            S_SCAN_RD: begin
                o_cmd.settle_clr = i_stat.scan_end;
                o_cmd.buf_rd     = !i_stat.scan_end;
            end
            S_SCAN_USE: o_cmd.scan_use = 1'b1;
            S_LEN_USE:  o_cmd.len_use  = 1'b1;
            S_COPY_RD: begin
                o_cmd.resp_start = i_stat.copy_done;
                o_cmd.buf_rd     = !i_stat.copy_done;
            end
            S_COPY_USE: o_cmd.copy_use = 1'b1;
            S_EM_HDR: begin
                o_cmd.emit = i_stat.slot_free;
                o_cmd.esel = E_HDR;
            end
            S_EM_CNT: begin
                o_cmd.emit = i_stat.slot_free;
                o_cmd.esel = E_CNT;
            end
            S_EM_RD: o_cmd.st_rd = !i_stat.emit_done;
            S_EM_DAT: begin
                o_cmd.emit = i_stat.slot_free;
                o_cmd.esel = E_DAT;
            end
            S_EM_S1: begin
                o_cmd.emit = i_stat.slot_free;
                o_cmd.esel = E_S1;
            end
            S_EM_S2: begin
                o_cmd.emit       = i_stat.slot_free;
                o_cmd.settle_clr = i_stat.slot_free;
                o_cmd.esel       = E_S2;
            end
            S_LOC_EM: begin
                o_cmd.emit = i_stat.slot_free;
                o_cmd.esel = E_LOC;
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// ===== src/serial_register_access_fletcher.sv =====
// Serial register access responder. Each input item is a received byte, a
// time tick, a local read or a local write. Ticks and local writes are taken
// in the idle state; a local read then emits its result, waiting on the
// output if needed. A received byte passes through a settle state. A byte
// that completes a frame runs the controller over the frame buffer through
// its single registered read port: a read and a use state per frame byte for
// the Fletcher check, a decide state, then a read and a use state per data
// byte for a write frame's store copy, and a read and an emit state per data
// byte of a read response besides the header, count and check bytes.
// A failed check rescans the buffer byte by byte and repeats the check on
// a later header. Results leave through an output register, so the item
// after a finished response is taken while the last byte waits. The store
// reads as zero from reset without a clearing pass.
// Depends on sra_pkg, sra_if.sv, sra_dp and sra_ctrl.
`default_nettype none

module serial_register_access_fletcher #(
    parameter int STORE_SIZE = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata,
    sra_in_if.sink           i_in,
    sra_out_if.source        o_out
);
    import sra_pkg::*;

    t_cmd  cmd;
    t_stat st;

    // Storage, counters and output register.
    sra_dp #(
        .STORE_SIZE(STORE_SIZE)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in       (i_in),
        .o_out      (o_out),
        .i_cmd      (cmd),
        .o_stat     (st)
    );

    // Frame sequencing.
    sra_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_stat (st),
        .o_cmd  (cmd)
    );

    // A byte is only loaded into the output register when the slot is free.
    a_emit_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> st.slot_free)
        else $error("result item loaded into a busy output register");

    // No item is taken while a response is being emitted.
    a_rdy_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.rdy |-> !cmd.emit)
        else $error("input accepted during emission");

    // Buffer reads never overlap with taking a new item.
    a_rdy_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.buf_rd |-> !cmd.rdy)
        else $error("frame buffer read while accepting an item");

    // A local read holds off the next item: ready is low in the next cycle.
    a_lread: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.mode == M_LREAD) |=> !i_in.ready)
        else $error("local read did not enter its emit state");

endmodule

`default_nettype wire
